// ===== design/bcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade filter package
// Shared constants, register indexes, state and command types for the
// biquad cascade filter core.
// ----------------------------------------------------------------------------
package bcf_pkg;

   localparam int MAX_SECTIONS = 4;
   localparam int SEC_IDX_W    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SEC_CNT_W    = 3;
   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 16;
   localparam int PACKED_W     = 64;
   localparam int GAIN_W       = 32;
   localparam int DELAY_W      = 32;
   localparam int PROD_W       = SAMPLE_W + GAIN_W;
   localparam int CSR_IDX_W    = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_B0       = 3'd0,
      REG_B1       = 3'd1,
      REG_B2       = 3'd2,
      REG_A1       = 3'd3,
      REG_A2       = 3'd4,
      REG_GAIN     = 3'd5,
      REG_SECTIONS = 3'd6
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_B0,
      S_Y,
      S_T1,
      S_FD,
      S_T2,
      S_SD,
      S_GAIN,
      S_OUT
   } state_type;

   // Operand pairing for the shared multiplier.
   typedef enum logic [2:0] {
      MUL_B0_X,
      MUL_B1_X,
      MUL_B2_X,
      MUL_A1_Y,
      MUL_A2_Y,
      MUL_GAIN_X
   } mul_sel_type;

   // What the datapath does with the registered product this cycle.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_Y,
      OP_T_SD,
      OP_FD,
      OP_T,
      OP_SD,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic                 load_x;
      logic                 mul_en;
      mul_sel_type          mul_sel;
      op_type               op;
      logic [SEC_IDX_W-1:0] sec;
   } cmd_type;

   typedef struct packed {
      logic [SEC_CNT_W-1:0] count;
      logic                 out_free;
   } status_type;

endpackage

// ===== design/biquad_cascade_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade filter core
// Up to four transposed direct form II biquad sections in cascade followed
// by a Q8.24 output gain, sharing one 16 x 32 multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid / req_ready  req_sample_in  (Q1.15)
//  rsp_      out        rsp_valid / rsp_ready  rsp_sample_out (Q1.15, saturated)
//  csr_      in         csr_write_enable       csr_index, csr_write_data
//
// A sample is accepted, then runs S_MUL_B0, S_Y, S_T1, S_FD, S_T2, S_SD for each
// section in use, then gain multiply and output; the single shared multiplier sets this.
// One sample is in work at a time; req_ready is high only while idle.
// The result register lets the next sample be accepted while a beat waits;
// a finished sample stalls in the output step until the register is free.
// Reset is synchronous, restores configuration defaults and clears all section delays.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [bcf_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bcf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                csr_write_enable,
   input  logic [bcf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bcf_pkg::PACKED_W-1:0]        csr_write_data
);

   bcf_pkg::cmd_type    cmd;
   bcf_pkg::status_type status;

   bcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_sample_in    (req_sample_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_sample_out   (rsp_sample_out),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== design/bcf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade filter controller
// Sequences the shared multiplier and the accumulate steps through each
// section in use, then the output gain, and hands the result over.
// ----------------------------------------------------------------------------
module bcf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bcf_pkg::status_type  status,
   output bcf_pkg::cmd_type     cmd
);

   bcf_pkg::state_type state_ff, state_in;
   logic [bcf_pkg::SEC_IDX_W-1:0] sec_ff, sec_in;
   logic last_sec;
   logic accept;

   assign accept   = req_valid && (state_ff == bcf_pkg::S_IDLE);
   assign last_sec = (bcf_pkg::SEC_CNT_W'(sec_ff) + bcf_pkg::SEC_CNT_W'(1)) >= status.count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bcf_pkg::S_IDLE;
         sec_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sec_ff   <= sec_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      sec_in   = sec_ff;
      case (state_ff)
         bcf_pkg::S_IDLE: begin
            sec_in = '0;
            if (req_valid) begin
               if (status.count == '0) begin
                  state_in = bcf_pkg::S_GAIN;
               end else begin
                  state_in = bcf_pkg::S_MUL_B0;
               end
            end
         end
         bcf_pkg::S_MUL_B0: state_in = bcf_pkg::S_Y;
         bcf_pkg::S_Y:      state_in = bcf_pkg::S_T1;
         bcf_pkg::S_T1:     state_in = bcf_pkg::S_FD;
         bcf_pkg::S_FD:     state_in = bcf_pkg::S_T2;
         bcf_pkg::S_T2:     state_in = bcf_pkg::S_SD;
         bcf_pkg::S_SD: begin
            if (last_sec) begin
               state_in = bcf_pkg::S_GAIN;
            end else begin
               sec_in   = sec_ff + bcf_pkg::SEC_IDX_W'(1);
               state_in = bcf_pkg::S_MUL_B0;
            end
         end
         bcf_pkg::S_GAIN:   state_in = bcf_pkg::S_OUT;
         bcf_pkg::S_OUT: begin
            if (status.out_free) begin
               state_in = bcf_pkg::S_IDLE;
            end
         end
         default:           state_in = bcf_pkg::S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.load_x  = 1'b0;
      cmd.mul_en  = 1'b0;
      cmd.mul_sel = bcf_pkg::MUL_B0_X;
      cmd.op      = bcf_pkg::OP_NONE;
      cmd.sec     = sec_ff;
      case (state_ff)
         bcf_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.load_x = accept;
         end
         bcf_pkg::S_MUL_B0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bcf_pkg::MUL_B0_X;
         end
         bcf_pkg::S_Y: begin
            cmd.op      = bcf_pkg::OP_Y;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bcf_pkg::MUL_B1_X;
         end
         bcf_pkg::S_T1: begin
            cmd.op      = bcf_pkg::OP_T_SD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bcf_pkg::MUL_A1_Y;
         end
         bcf_pkg::S_FD: begin
            cmd.op      = bcf_pkg::OP_FD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bcf_pkg::MUL_B2_X;
         end
         bcf_pkg::S_T2: begin
            cmd.op      = bcf_pkg::OP_T;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bcf_pkg::MUL_A2_Y;
         end
         bcf_pkg::S_SD: begin
            cmd.op = bcf_pkg::OP_SD;
         end
         bcf_pkg::S_GAIN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = bcf_pkg::MUL_GAIN_X;
         end
         bcf_pkg::S_OUT: begin
            if (status.out_free) begin
               cmd.op = bcf_pkg::OP_OUT;
            end
         end
         default: begin
            cmd.op = bcf_pkg::OP_NONE;
         end
      endcase
   end

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcf_pkg::S_OUT && !status.out_free) |=> (state_ff == bcf_pkg::S_OUT))
      else $error("controller left the output state while the result beat was blocked");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (state_ff == bcf_pkg::S_MUL_B0 || state_ff == bcf_pkg::S_GAIN))
      else $error("accepted sample did not start a section or the gain step");

   a_section_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcf_pkg::S_SD) |=>
         (state_ff == bcf_pkg::S_MUL_B0 || state_ff == bcf_pkg::S_GAIN))
      else $error("section end not followed by next section or gain");

endmodule

// ===== design/bcf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade filter datapath
// Configuration registers, per-section delay registers, the shared
// multiplier with its product register, accumulate and saturate logic and
// the result register.
// ----------------------------------------------------------------------------
module bcf_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [bcf_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                                   csr_write_enable,
   input  logic [bcf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [bcf_pkg::PACKED_W-1:0]           csr_write_data,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic signed [bcf_pkg::SAMPLE_W-1:0]    rsp_sample_out,
   input  bcf_pkg::cmd_type                       cmd,
   output bcf_pkg::status_type                    status
);

   localparam int WIDE_W = bcf_pkg::PROD_W + 2;

   function automatic logic signed [bcf_pkg::SAMPLE_W-1:0] sat16(
      input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_W'(32767)) begin
         sat16 = 16'sh7fff;
      end else if (v < -WIDE_W'(32768)) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[bcf_pkg::SAMPLE_W-1:0];
      end
   endfunction

   function automatic logic signed [bcf_pkg::DELAY_W-1:0] sat32(
      input logic signed [WIDE_W-1:0] v);
      if (v > WIDE_W'(64'sh7fff_ffff)) begin
         sat32 = 32'sh7fff_ffff;
      end else if (v < -WIDE_W'(64'sh8000_0000)) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[bcf_pkg::DELAY_W-1:0];
      end
   endfunction

   logic [bcf_pkg::PACKED_W-1:0]       b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [bcf_pkg::GAIN_W-1:0]  gain_ff;
   logic [bcf_pkg::SEC_CNT_W-1:0]      sections_ff;

   logic signed [bcf_pkg::DELAY_W-1:0] fd_ff [bcf_pkg::MAX_SECTIONS];
   logic signed [bcf_pkg::DELAY_W-1:0] sd_ff [bcf_pkg::MAX_SECTIONS];
   logic signed [bcf_pkg::DELAY_W-1:0] fd_sel, sd_sel, delay_in;

   logic signed [bcf_pkg::SAMPLE_W-1:0] x_ff, y_ff, y_in;
   logic signed [bcf_pkg::PROD_W-1:0]   product_ff, product_in;
   logic signed [WIDE_W-1:0]            t_ff, t_in;
   logic signed [WIDE_W-1:0]            prod_wide, y_round, out_round, diff;

   logic [bcf_pkg::PACKED_W-1:0]        packed_sel;
   logic signed [bcf_pkg::COEF_W-1:0]   coef;
   logic signed [bcf_pkg::SAMPLE_W-1:0] mul_a;
   logic signed [bcf_pkg::GAIN_W-1:0]   mul_b;

   logic                                out_valid_ff;
   logic signed [bcf_pkg::SAMPLE_W-1:0] out_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff       <= 64'h4000_4000_4000_4000;
         b1_ff       <= '0;
         b2_ff       <= '0;
         a1_ff       <= '0;
         a2_ff       <= '0;
         gain_ff     <= 32'sh0100_0000;
         sections_ff <= bcf_pkg::SEC_CNT_W'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            bcf_pkg::REG_B0:       b0_ff       <= csr_write_data;
            bcf_pkg::REG_B1:       b1_ff       <= csr_write_data;
            bcf_pkg::REG_B2:       b2_ff       <= csr_write_data;
            bcf_pkg::REG_A1:       a1_ff       <= csr_write_data;
            bcf_pkg::REG_A2:       a2_ff       <= csr_write_data;
            bcf_pkg::REG_GAIN:     gain_ff     <= csr_write_data[bcf_pkg::GAIN_W-1:0];
            bcf_pkg::REG_SECTIONS: sections_ff <= csr_write_data[bcf_pkg::SEC_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign status.count = (sections_ff > bcf_pkg::SEC_CNT_W'(bcf_pkg::MAX_SECTIONS)) ?
                         bcf_pkg::SEC_CNT_W'(bcf_pkg::MAX_SECTIONS) : sections_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;

   // Multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         bcf_pkg::MUL_B1_X: packed_sel = b1_ff;
         bcf_pkg::MUL_B2_X: packed_sel = b2_ff;
         bcf_pkg::MUL_A1_Y: packed_sel = a1_ff;
         bcf_pkg::MUL_A2_Y: packed_sel = a2_ff;
         default:           packed_sel = b0_ff;
      endcase
   end

   assign coef = packed_sel[cmd.sec*bcf_pkg::COEF_W +: bcf_pkg::COEF_W];

   always_comb begin
      mul_a = x_ff;
      mul_b = bcf_pkg::GAIN_W'(coef);
      case (cmd.mul_sel)
         bcf_pkg::MUL_A1_Y,
         bcf_pkg::MUL_A2_Y:   mul_a = y_ff;
         bcf_pkg::MUL_GAIN_X: mul_b = gain_ff;
         default: ;
      endcase
   end

   assign product_in = mul_a * mul_b;

   // Accumulate, round and saturate on the registered product.
   assign fd_sel    = fd_ff[cmd.sec];
   assign sd_sel    = sd_ff[cmd.sec];
   assign prod_wide = WIDE_W'(product_ff);
   assign y_round   = (prod_wide + WIDE_W'(fd_sel) + WIDE_W'(8192)) >>> 14;
   assign y_in      = sat16(y_round);
   assign out_round = (prod_wide + WIDE_W'(8388608)) >>> 24;
   assign diff      = t_ff - prod_wide;
   assign delay_in  = sat32(diff);

   always_comb begin
      t_in = t_ff;
      case (cmd.op)
         bcf_pkg::OP_T_SD: t_in = prod_wide + WIDE_W'(sd_sel);
         bcf_pkg::OP_T:    t_in = prod_wide;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         product_ff <= product_in;
      end
      t_ff <= t_in;
      if (cmd.load_x) begin
         x_ff <= req_sample_in;
      end else if (cmd.op == bcf_pkg::OP_SD) begin
         x_ff <= y_ff;
      end
      if (cmd.op == bcf_pkg::OP_Y) begin
         y_ff <= y_in;
      end
      if (cmd.op == bcf_pkg::OP_OUT) begin
         out_ff <= sat16(out_round);
      end
   end

   // Section delays are filter state and are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bcf_pkg::MAX_SECTIONS; i++) begin
            fd_ff[i] <= '0;
            sd_ff[i] <= '0;
         end
      end else begin
         if (cmd.op == bcf_pkg::OP_FD) begin
            fd_ff[cmd.sec] <= delay_in;
         end
         if (cmd.op == bcf_pkg::OP_SD) begin
            sd_ff[cmd.sec] <= delay_in;
         end
      end
   end

   // Result register: a new beat may be loaded in the cycle the old one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == bcf_pkg::OP_OUT) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_ff;

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bcf_pkg::OP_OUT) |=> out_valid_ff)
      else $error("result register not valid after the output step");

endmodule

// ===== bench/bcf_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade filter scoreboard
// Bit-exact model of the section cascade and output gain, and an ordered
// queue of the output samples it predicts, checked as result beats arrive.
// ----------------------------------------------------------------------------
package bcf_tb_pkg;

   import bcf_pkg::*;

   localparam longint DELAY_MAX  = 64'sd2147483647;
   localparam longint DELAY_MIN  = -64'sd2147483648;
   localparam longint SAMPLE_MAX = 64'sd32767;
   localparam longint SAMPLE_MIN = -64'sd32768;

   class filter_scoreboard;

      logic [PACKED_W-1:0]        b0_word;
      logic [PACKED_W-1:0]        b1_word;
      logic [PACKED_W-1:0]        b2_word;
      logic [PACKED_W-1:0]        a1_word;
      logic [PACKED_W-1:0]        a2_word;
      longint                     gain_q824;
      logic [SEC_CNT_W-1:0]       sections;
      longint                     first_delay [MAX_SECTIONS];
      longint                     second_delay [MAX_SECTIONS];
      logic signed [SAMPLE_W-1:0] expected_samples [$];
      int                         error_count;

      function new();
         b0_word     = 64'h4000_4000_4000_4000;
         b1_word     = '0;
         b2_word     = '0;
         a1_word     = '0;
         a2_word     = '0;
         gain_q824   = 64'sd16777216;
         sections    = SEC_CNT_W'(1);
         error_count = 0;
         foreach (first_delay[i]) begin
            first_delay[i]  = 0;
            second_delay[i] = 0;
         end
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] index, logic [PACKED_W-1:0] data);
         case (index)
            REG_B0:       b0_word = data;
            REG_B1:       b1_word = data;
            REG_B2:       b2_word = data;
            REG_A1:       a1_word = data;
            REG_A2:       a2_word = data;
            REG_GAIN:     gain_q824 = longint'($signed(data[GAIN_W-1:0]));
            REG_SECTIONS: sections = data[SEC_CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function longint coef(logic [PACKED_W-1:0] word, int sec);
         return longint'($signed(word[COEF_W*sec +: COEF_W]));
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Round half up, then saturate to a Q1.15 sample.
      function longint round_to_sample(longint v, int frac_bits);
         return clamp((v + (longint'(1) <<< (frac_bits - 1))) >>> frac_bits,
                      SAMPLE_MIN, SAMPLE_MAX);
      endfunction

      function void add_sample(logic signed [SAMPLE_W-1:0] sample);
         longint x;
         longint y;
         longint acc;
         longint scaled;
         int     depth;
         x     = sample;
         depth = (sections > MAX_SECTIONS) ? MAX_SECTIONS : int'(sections);
         for (int s = 0; s < depth; s++) begin
            acc = coef(b0_word, s) * x + first_delay[s];
            y   = round_to_sample(acc, 14);
            first_delay[s]  = clamp(coef(b1_word, s) * x + second_delay[s]
                                    - coef(a1_word, s) * y, DELAY_MIN, DELAY_MAX);
            second_delay[s] = clamp(coef(b2_word, s) * x - coef(a2_word, s) * y,
                                    DELAY_MIN, DELAY_MAX);
            x = y;
         end
         scaled = round_to_sample(x * gain_q824, 24);
         expected_samples = {expected_samples, scaled[SAMPLE_W-1:0]};
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      task report(string msg);
         $display("mismatch at %0t ns: %s", $time, msg);
         error_count++;
      endtask

      task check_sample(logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (expected_samples.size() == 0) begin
            report($sformatf("result beat with nothing expected, sample_out %0d", got));
         end else begin
            want = expected_samples.pop_front();
            if (got !== want) begin
               report($sformatf("sample_out %0d, expected %0d", got, want));
            end
         end
      endtask

   endclass

endpackage

// ===== bench/biquad_cascade_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade filter core testbench
// Drives samples and register writes into the core, predicts every output
// sample with the scoreboard model and checks the results in order, under
// random idling on both channels and long back-pressure stalls.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_core_tb;

   import bcf_pkg::*;
   import bcf_tb_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int DRAIN_CYCLES  = 40;
   localparam int STALL_CYCLES  = 400;
   localparam int PHASES        = 14;
   localparam int PHASE_SAMPLES = 102;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       csr_write_enable;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [PACKED_W-1:0]        csr_write_data;

   filter_scoreboard sb = new();
   logic             calm = 1'b0;
   logic             stall_request = 1'b0;

   biquad_cascade_filter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: random idling, plus a long hold-off when one is requested.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_left    = STALL_CYCLES;
            stall_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 8);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_sample(rsp_sample_out);
      end
   end

   // Leaves valid high after the beat, so that a following sample goes
   // straight on; stop_sending lowers it.
   task automatic send_sample(logic signed [SAMPLE_W-1:0] sample);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      sb.add_sample(sample);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic settle();
      stop_sending();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [PACKED_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      sb.configure(index, data);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Style 0 is fully random, style 1 gives small, mostly stable filters and
   // style 2 picks corner values for every register.
   task automatic apply_setting(int style);
      logic [PACKED_W-1:0] word;
      logic [COEF_W-1:0]   c;
      logic [GAIN_W-1:0]   g;
      logic [SEC_CNT_W-1:0] count;
      for (int r = REG_B0; r <= REG_A2; r++) begin
         for (int k = 0; k < MAX_SECTIONS; k++) begin
            case (style)
               0: c = COEF_W'($urandom);
               1: begin
                  c = COEF_W'($urandom_range(4095));
                  if ($urandom_range(1)) c = -c;
               end
               default: begin
                  case ($urandom_range(4))
                     0: c = 16'h7FFF;
                     1: c = 16'h8000;
                     2: c = 16'h0000;
                     3: c = 16'h4000;
                     default: c = 16'hC000;
                  endcase
               end
            endcase
            word[COEF_W*k +: COEF_W] = c;
         end
         write_reg(CSR_IDX_W'(r), word);
      end
      case (style)
         0: g = $urandom;
         1: begin
            g = 32'h0080_0000 + $urandom_range(32'h0100_0000);
            if ($urandom_range(3) == 0) g = -g;
         end
         default: begin
            case ($urandom_range(4))
               0: g = 32'h7FFF_FFFF;
               1: g = 32'h8000_0000;
               2: g = 32'h0000_0000;
               3: g = 32'h0100_0000;
               default: g = 32'hFF00_0000;
            endcase
         end
      endcase
      write_reg(REG_GAIN, {$urandom, g});
      case (style)
         0: count = SEC_CNT_W'($urandom_range(7));
         1: count = SEC_CNT_W'($urandom_range(1, MAX_SECTIONS));
         default: begin
            case ($urandom_range(4))
               0: count = 3'd0;
               1: count = 3'd1;
               2: count = 3'd4;
               3: count = 3'd5;
               default: count = 3'd7;
            endcase
         end
      endcase
      write_reg(REG_SECTIONS, {$urandom, 29'd0, count});
      if (style == 0) write_reg(CSR_UNUSED_INDEX, {$urandom, $urandom});
      end_writes();
   endtask

   initial begin
      logic signed [SAMPLE_W-1:0] s;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_in    = '0;
      csr_write_enable = 1'b0;
      csr_index        = REG_B0;
      csr_write_data   = '0;
      s                = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Settings after reset: one section passing the sample through at unity.
      send_sample(16'sh0000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      send_sample(16'sh4000);

      // Largest and smallest gain, so that the output saturates both ways.
      settle();
      write_reg(REG_GAIN, 64'h0000_0000_7FFF_FFFF);
      end_writes();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      settle();
      write_reg(REG_GAIN, 64'h0000_0000_8000_0000);
      end_writes();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'shFFFF);

      // Extreme coefficients in all four sections drive the delays into
      // saturation.
      settle();
      write_reg(REG_B0, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(REG_B1, 64'h8000_8000_8000_8000);
      write_reg(REG_B2, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(REG_A1, 64'h8000_8000_8000_8000);
      write_reg(REG_A2, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(REG_GAIN, 64'h0000_0000_0100_0000);
      write_reg(REG_SECTIONS, 64'd4);
      end_writes();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);

      // A count of zero bypasses every section; a count above the maximum
      // runs all of them.
      settle();
      write_reg(REG_SECTIONS, 64'd0);
      end_writes();
      send_sample(16'sh8000);
      send_sample(16'sh3039);
      settle();
      write_reg(REG_SECTIONS, 64'd7);
      end_writes();
      send_sample(16'sh03E8);
      send_sample(16'shFC18);

      // A write to the unused index must change nothing.
      settle();
      write_reg(CSR_UNUSED_INDEX, 64'hFFFF_FFFF_FFFF_FFFF);
      end_writes();
      send_sample(16'sh01F4);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         apply_setting(phase % 3);
         calm = (phase == 9);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (phase == 4 && n == 20) stall_request = 1'b1;
            if (phase == 7 && n == 50) settle();
            case ($urandom_range(19))
               0, 1: begin
                  case ($urandom_range(4))
                     0: s = 16'sh7FFF;
                     1: s = 16'sh8000;
                     2: s = 16'sh0000;
                     3: s = 16'sh0001;
                     default: s = 16'shFFFF;
                  endcase
               end
               2, 3, 4: ; // hold the previous sample, a step input
               default: s = SAMPLE_W'($urandom);
            endcase
            send_sample(s);
         end
      end
      calm = 1'b0;

      settle();
      if (sb.error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bcf_pkg.sv
design/bcf_ctrl.sv
design/bcf_datapath.sv
design/biquad_cascade_filter_core.sv
bench/bcf_tb_pkg.sv
bench/biquad_cascade_filter_core_tb.sv
